// ===== rtl/core/mpts_pkg.sv =====
// Shared types and constants for the multichannel pulse train scheduler.
`timescale 1ns / 1ps
`default_nettype none
package mpts_pkg;

	// Event store geometry
	localparam int STORE_DEPTH = 16;
	localparam int SIDX_W      = 4;
	localparam int SCNT_W      = 5;
	localparam int ENTRY_W     = 32;
	// Stored word carries a fresh flag above the entry
	localparam int STORED_W    = ENTRY_W + 1;

	localparam logic [15:0] IDLE_INTERVAL = 16'd15;
	localparam logic [16:0] START_BASE    = 17'd15;
	localparam logic [31:0] TIME_FOLD_MASK = 32'h0fff_ffff;

	typedef enum logic [1:0] {
		OP_APPLY = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_NEXT  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPLY,
		S_STOP,
		S_ST_RD,
		S_ST_WR,
		S_SEL_SCAN,
		S_PROC_RD,
		S_PROC_MV,
		S_PROC_PUSH,
		S_FIN_SCAN,
		S_CLR_RD,
		S_CLR_WR
	} state_t;

	// Per-channel timing settings
	typedef struct packed {
		logic [15:0] high_len;
		logic [15:0] low_len;
		logic [15:0] phase;
		logic [30:0] pulses;
	} param_t;

endpackage
`default_nettype wire

// ===== rtl/core/multichannel_pulse_train_scheduler_core.sv =====
// Top level of the multichannel pulse train scheduler.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and cannot be
// held off. Apply and stop walk the channels; start reads each channel's
// settings and writes an event for each masked channel while the store has
// room, or returns at once when rejected. Next returns at once on an empty
// store; otherwise each retired event costs one pass over the event store
// plus a read, move and push step, then one more such pass finds no further
// event at the current time, then a final pass finds the new earliest event
// and, when entries remain, they are rewritten one by one. All of this is
// paced by the single read port of the event store RAM, which is walked one
// entry per cycle. No clearing pass is needed after reset.
module multichannel_pulse_train_scheduler_core #(
	parameter int CHANNEL_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] channel_mask,
	input  wire logic [15:0] high_len,
	input  wire logic [15:0] low_len,
	input  wire logic [15:0] start_phase,
	input  wire logic [30:0] pulse_count,
	output logic             done,
	output logic [15:0]      set_mask,
	output logic [15:0]      clear_mask,
	output logic [15:0]      next_interval,
	output logic             start_error
);
	localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int SW = mpts_pkg::SIDX_W;
	localparam int NW = mpts_pkg::SCNT_W;
	localparam int PW = $bits(mpts_pkg::param_t);

	mpts_pkg::state_t state_q, state_d;

	logic [CHANNEL_COUNT-1:0] mask_q, applied_q, active_q, set_acc_q, clr_acc_q;
	mpts_pkg::op_t            op_q;
	logic [15:0]              high_q, low_q, phase_q;
	logic [30:0]              pc_q;
	logic [NW-1:0]            count_q;
	logic [CW-1:0]            ch_q;

	// Scan pipeline
	logic [NW-1:0]            scan_i_q;
	logic                     v_s1;
	logic [SW-1:0]            idx_s1;
	logic [31:0]              best_q;
	logic [SW-1:0]            best_idx_q;
	logic                     best_ok_q;

	logic                     first_q;
	logic [26:0]              cur_q;
	logic [31:0]              sel_e_q;
	logic [SW-1:0]            sel_idx_q;
	logic                     keep_q;
	logic [32:0]              push_q;
	logic                     clr_bit_q;
	logic [SW-1:0]            clr_i_q;
	logic [15:0]              int_q;

	logic                     done_q, start_error_q;
	logic [15:0]              set_mask_q, clear_mask_q, next_interval_q;

	// RAM ports
	logic                           store_we;
	logic [SW-1:0]                  store_waddr, store_raddr;
	logic [mpts_pkg::STORED_W-1:0]  store_wdata, store_rdata;
	logic                           par_we;
	logic [CW-1:0]                  par_waddr, par_raddr;
	mpts_pkg::param_t               par_wdata, par_rdata;
	logic [PW-1:0]                  par_rbits;
	logic                           edg_we;
	logic [CW-1:0]                  edg_waddr, edg_raddr;
	logic [31:0]                    edg_wdata, edg_rdata;

	logic [CHANNEL_COUNT-1:0] mask_in;
	logic                     accept, start_fail, scan_done, fin, sel_take;
	logic [31:0]              edg_dec;
	logic [15:0]              int_calc, int_d;
	logic [CW-1:0]            sel_ch;
	logic [15:0]              sel_len;
	logic [31:0]              push_val;

	assign busy      = (state_q != mpts_pkg::S_IDLE);
	assign accept    = start && !busy;
	assign mask_in   = channel_mask[CHANNEL_COUNT-1:0];
	assign start_fail = ((applied_q & mask_in) != mask_in) || ((active_q & mask_in) != '0);
	assign scan_done = (scan_i_q == count_q) && !v_s1;
	assign sel_take  = best_ok_q && (first_q || (best_q[31:5] == cur_q));
	assign edg_dec   = edg_rdata - 32'd1;
	assign sel_ch    = sel_e_q[1 +: CW];
	assign sel_len   = sel_e_q[0] ? par_rdata.high_len : par_rdata.low_len;
	assign push_val  = (({16'd0, sel_len} << 5) + sel_e_q) ^ 32'd1;
	assign int_calc  = (count_q == '0) ? mpts_pkg::IDLE_INTERVAL
	                                   : 16'(best_q[31:5] - cur_q);
	assign int_d     = (state_q == mpts_pkg::S_FIN_SCAN) ? int_calc : int_q;
	assign par_rdata = mpts_pkg::param_t'(par_rbits);

	// Event store, per-channel settings and remaining edge counts
	mpts_ram #(.WIDTH(mpts_pkg::STORED_W), .DEPTH(mpts_pkg::STORE_DEPTH)) u_store (
		.clk(clk), .we(store_we), .waddr(store_waddr), .wdata(store_wdata),
		.raddr(store_raddr), .rdata(store_rdata)
	);
	mpts_ram #(.WIDTH(PW), .DEPTH(CHANNEL_COUNT)) u_param (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(PW'(par_wdata)),
		.raddr(par_raddr), .rdata(par_rbits)
	);
	mpts_ram #(.WIDTH(32), .DEPTH(CHANNEL_COUNT)) u_edges (
		.clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
		.raddr(edg_raddr), .rdata(edg_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpts_pkg::S_IDLE: begin
				if (accept) begin
					unique case (mpts_pkg::op_t'(op))
						mpts_pkg::OP_APPLY: state_d = mpts_pkg::S_APPLY;
						mpts_pkg::OP_STOP:  state_d = mpts_pkg::S_STOP;
						mpts_pkg::OP_START: state_d = start_fail ? mpts_pkg::S_IDLE
						                                         : mpts_pkg::S_ST_RD;
						mpts_pkg::OP_NEXT:  state_d = (count_q == '0) ? mpts_pkg::S_IDLE
						                                              : mpts_pkg::S_SEL_SCAN;
						default:            state_d = mpts_pkg::S_IDLE;
					endcase
				end
			end
			mpts_pkg::S_APPLY, mpts_pkg::S_STOP: begin
				if (ch_q == '0) state_d = mpts_pkg::S_IDLE;
			end
			mpts_pkg::S_ST_RD: begin
				if (mask_q[ch_q]) state_d = mpts_pkg::S_ST_WR;
				else if (ch_q == '0) state_d = mpts_pkg::S_IDLE;
			end
			mpts_pkg::S_ST_WR: begin
				state_d = (ch_q == '0) ? mpts_pkg::S_IDLE : mpts_pkg::S_ST_RD;
			end
			mpts_pkg::S_SEL_SCAN: begin
				if (scan_done) state_d = sel_take ? mpts_pkg::S_PROC_RD : mpts_pkg::S_FIN_SCAN;
			end
			mpts_pkg::S_PROC_RD:   state_d = mpts_pkg::S_PROC_MV;
			mpts_pkg::S_PROC_MV:   state_d = mpts_pkg::S_PROC_PUSH;
			mpts_pkg::S_PROC_PUSH: state_d = mpts_pkg::S_SEL_SCAN;
			mpts_pkg::S_FIN_SCAN: begin
				if (scan_done) state_d = (count_q == '0) ? mpts_pkg::S_IDLE : mpts_pkg::S_CLR_RD;
			end
			mpts_pkg::S_CLR_RD: state_d = mpts_pkg::S_CLR_WR;
			mpts_pkg::S_CLR_WR: begin
				state_d = ({1'b0, clr_i_q} == count_q - NW'(1)) ? mpts_pkg::S_IDLE
				                                                : mpts_pkg::S_CLR_RD;
			end
			default: state_d = mpts_pkg::S_IDLE;
		endcase
	end

	assign fin = (state_d == mpts_pkg::S_IDLE) && (busy || accept);

	// RAM control
	always_comb begin
		store_we    = 1'b0;
		store_waddr = count_q[SW-1:0];
		store_wdata = push_q;
		store_raddr = scan_i_q[SW-1:0];
		par_we      = 1'b0;
		par_waddr   = ch_q;
		par_wdata   = '{high_len: high_q, low_len: low_q, phase: phase_q, pulses: pc_q};
		par_raddr   = ch_q;
		edg_we      = 1'b0;
		edg_waddr   = ch_q;
		edg_wdata   = 32'd1;
		edg_raddr   = sel_ch;
		unique case (state_q)
			mpts_pkg::S_APPLY: par_we = mask_q[ch_q];
			mpts_pkg::S_STOP:  edg_we = mask_q[ch_q];
			mpts_pkg::S_ST_WR: begin
				edg_we      = 1'b1;
				edg_wdata   = {par_rdata.pulses, 1'b0};
				store_we    = (count_q != NW'(mpts_pkg::STORE_DEPTH));
				store_wdata = {1'b0, 27'({1'b0, par_rdata.phase} + mpts_pkg::START_BASE),
				               4'(ch_q), 1'b1};
			end
			mpts_pkg::S_PROC_RD: begin
				store_raddr = SW'(count_q - NW'(1));
				par_raddr   = sel_ch;
			end
			mpts_pkg::S_PROC_MV: begin
				store_we    = 1'b1;
				store_waddr = sel_idx_q;
				store_wdata = store_rdata;
				edg_we      = 1'b1;
				edg_waddr   = sel_ch;
				edg_wdata   = edg_dec;
			end
			mpts_pkg::S_PROC_PUSH: store_we = keep_q;
			mpts_pkg::S_CLR_RD: store_raddr = clr_i_q;
			mpts_pkg::S_CLR_WR: begin
				store_we    = 1'b1;
				store_waddr = clr_i_q;
				store_wdata = {1'b0, clr_bit_q ? (store_rdata[31:0] & mpts_pkg::TIME_FOLD_MASK)
				                               : store_rdata[31:0]};
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mpts_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q <= '0;
			active_q  <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			done_q <= fin;
			if (accept) begin
				unique case (mpts_pkg::op_t'(op))
					mpts_pkg::OP_APPLY: applied_q <= applied_q | mask_in;
					mpts_pkg::OP_START: begin
						if (!start_fail) begin
							active_q  <= active_q | mask_in;
							applied_q <= applied_q & ~mask_in;
						end
					end
					mpts_pkg::OP_STOP: active_q <= active_q & ~mask_in;
					default: ;
				endcase
			end
			// Store occupancy
			if (state_q == mpts_pkg::S_ST_WR && count_q != NW'(mpts_pkg::STORE_DEPTH))
				count_q <= count_q + NW'(1);
			else if (state_q == mpts_pkg::S_PROC_MV)
				count_q <= count_q - NW'(1);
			else if (state_q == mpts_pkg::S_PROC_PUSH && keep_q)
				count_q <= count_q + NW'(1);
			if (state_q == mpts_pkg::S_PROC_MV && edg_dec == '0)
				active_q[sel_ch] <= 1'b0;
			// Scan read pipeline valid
			if (state_d != state_q)
				v_s1 <= 1'b0;
			else if (state_q == mpts_pkg::S_SEL_SCAN || state_q == mpts_pkg::S_FIN_SCAN)
				v_s1 <= (scan_i_q != count_q);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= mpts_pkg::op_t'(op);
			mask_q    <= mask_in;
			high_q    <= high_len;
			low_q     <= low_len;
			phase_q   <= start_phase;
			pc_q      <= pulse_count;
			ch_q      <= CW'(CHANNEL_COUNT - 1);
			first_q   <= 1'b1;
			set_acc_q <= '0;
			clr_acc_q <= '0;
		end
		if (state_q == mpts_pkg::S_APPLY || state_q == mpts_pkg::S_STOP ||
		    state_q == mpts_pkg::S_ST_WR ||
		    (state_q == mpts_pkg::S_ST_RD && !mask_q[ch_q]))
			ch_q <= ch_q - CW'(1);
		// Scan: walk entries, keep the minimum
		if (state_d != state_q &&
		    (state_d == mpts_pkg::S_SEL_SCAN || state_d == mpts_pkg::S_FIN_SCAN)) begin
			scan_i_q  <= '0;
			best_ok_q <= 1'b0;
		end else if (state_q == mpts_pkg::S_SEL_SCAN || state_q == mpts_pkg::S_FIN_SCAN) begin
			if (scan_i_q != count_q) begin
				idx_s1   <= scan_i_q[SW-1:0];
				scan_i_q <= scan_i_q + NW'(1);
			end
			if (v_s1 && (state_q == mpts_pkg::S_FIN_SCAN || !store_rdata[32]) &&
			    (!best_ok_q || store_rdata[31:0] < best_q)) begin
				best_q     <= store_rdata[31:0];
				best_idx_q <= idx_s1;
				best_ok_q  <= 1'b1;
			end
		end
		if (state_q == mpts_pkg::S_SEL_SCAN && scan_done && sel_take) begin
			sel_e_q   <= best_q;
			sel_idx_q <= best_idx_q;
			cur_q     <= best_q[31:5];
			first_q   <= 1'b0;
		end
		// Retire one event
		if (state_q == mpts_pkg::S_PROC_MV) begin
			keep_q <= (edg_dec != '0);
			push_q <= {1'b1, push_val};
			if (sel_e_q[0]) set_acc_q[sel_ch] <= 1'b1;
			else clr_acc_q[sel_ch] <= 1'b1;
		end
		// Final pass and time fold
		if (state_q == mpts_pkg::S_FIN_SCAN && scan_done) begin
			int_q     <= int_calc;
			clr_bit_q <= (best_q[31:28] != 4'd0);
			clr_i_q   <= '0;
		end
		if (state_q == mpts_pkg::S_CLR_WR)
			clr_i_q <= clr_i_q + SW'(1);
		// Result registers
		if (fin) begin
			if (busy) begin
				set_mask_q      <= (op_q == mpts_pkg::OP_NEXT) ? 16'(set_acc_q) : 16'd0;
				clear_mask_q    <= (op_q == mpts_pkg::OP_NEXT) ? 16'(clr_acc_q) : 16'd0;
				next_interval_q <= (op_q == mpts_pkg::OP_NEXT) ? int_d : 16'd0;
				start_error_q   <= 1'b0;
			end else begin
				set_mask_q      <= 16'd0;
				clear_mask_q    <= 16'd0;
				next_interval_q <= (mpts_pkg::op_t'(op) == mpts_pkg::OP_NEXT)
				                   ? mpts_pkg::IDLE_INTERVAL : 16'd0;
				start_error_q   <= (mpts_pkg::op_t'(op) == mpts_pkg::OP_START) && start_fail;
			end
		end
	end

	assign done          = done_q;
	assign set_mask      = set_mask_q;
	assign clear_mask    = clear_mask_q;
	assign next_interval = next_interval_q;
	assign start_error   = start_error_q;

	// Store never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(mpts_pkg::STORE_DEPTH)) else $error("event store overflow");

	// A rejected start reports no edges
	a_err_no_edges: assert property (@(posedge clk) disable iff (!arst_n)
		(done && start_error) |-> (set_mask == 16'd0 && clear_mask == 16'd0))
		else $error("edges reported on rejected start");

	// The event store is only written while a request is in progress
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !store_we) else $error("store write while idle");

	// A removal always has an entry to remove
	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpts_pkg::S_PROC_MV) |-> (count_q != '0))
		else $error("removal from empty store");
endmodule
`default_nettype wire

// ===== rtl/core/mpts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mpts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, old data on collision
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the multichannel pulse train scheduler core.
`timescale 1ns / 1ps
module testbench;

	typedef struct {
		mpts_pkg::op_t op;
		logic [15:0] mask;
		logic [15:0] hi;
		logic [15:0] lo;
		logic [15:0] ph;
		logic [30:0] cnt;
		bit          drain;
	} request_t;

	typedef struct {
		logic [15:0] setm;
		logic [15:0] clrm;
		logic [15:0] ivl;
		logic        err;
	} event_out_t;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = mpts_pkg::OP_APPLY;
	logic [15:0] channel_mask = '0;
	logic [15:0] high_len = '0;
	logic [15:0] low_len = '0;
	logic [15:0] start_phase = '0;
	logic [30:0] pulse_count = '0;
	logic busy, done, start_error;
	logic [15:0] set_mask, clear_mask, next_interval;

	request_t   pending_q[$];
	event_out_t expected_q[$];
	int  fail_count = 0;
	int  idle_cycles = 0;
	int  taken_count = 0;
	bit  taken = 1'b0;
	bit  stim_done = 1'b0;

	// Shadow scheduler state
	logic [31:0] sh_store[16];
	int          sh_count;
	logic [15:0] sh_high[16], sh_low[16], sh_phase[16];
	logic [31:0] sh_total[16], sh_left[16];
	logic [15:0] sh_applied, sh_active;

	always #2 clk = ~clk;

	multichannel_pulse_train_scheduler_core #(.CHANNEL_COUNT(16)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.channel_mask(channel_mask), .high_len(high_len), .low_len(low_len),
		.start_phase(start_phase), .pulse_count(pulse_count), .done(done),
		.set_mask(set_mask), .clear_mask(clear_mask),
		.next_interval(next_interval), .start_error(start_error)
	);

	function automatic logic [31:0] earliest_entry();
		logic [31:0] m;
		m = 32'hffff_ffff;
		for (int i = 0; i < sh_count; i++)
			if (sh_store[i] < m) m = sh_store[i];
		return m;
	endfunction

	function automatic void store_push(logic [31:0] e);
		if (sh_count < 16) begin
			sh_store[sh_count] = e;
			sh_count++;
		end
	endfunction

	// Advance the shadow state by one request and return its result
	function automatic event_out_t schedule_step(request_t r);
		event_out_t res;
		logic [31:0] grp[16];
		logic [31:0] e, v, cur, m, len;
		int ng, keep, j;
		logic [3:0] ch;
		res = '{16'd0, 16'd0, 16'd0, 1'b0};
		case (r.op)
			mpts_pkg::OP_APPLY: begin
				sh_applied |= r.mask;
				for (int c = 0; c < 16; c++)
					if (r.mask[c]) begin
						sh_high[c] = r.hi;
						sh_low[c] = r.lo;
						sh_phase[c] = r.ph;
						sh_total[c] = {r.cnt, 1'b0};
					end
			end
			mpts_pkg::OP_START: begin
				if ((sh_applied & r.mask) != r.mask || (sh_active & r.mask) != 0)
					res.err = 1'b1;
				else begin
					sh_active |= r.mask;
					sh_applied &= ~r.mask;
					for (int c = 15; c >= 0; c--)
						if (r.mask[c]) begin
							v = 32'(sh_phase[c]) + 32'd15;
							store_push((v << 5) | (32'(c) << 1) | 32'd1);
							sh_left[c] = sh_total[c];
						end
				end
			end
			mpts_pkg::OP_STOP: begin
				for (int c = 0; c < 16; c++)
					if (r.mask[c]) sh_left[c] = 32'd1;
				sh_active &= ~r.mask;
			end
			default: begin
				if (sh_count == 0) begin
					res.ivl = mpts_pkg::IDLE_INTERVAL;
					return res;
				end
				cur = earliest_entry() >> 5;
				ng = 0;
				keep = 0;
				for (int i = 0; i < sh_count; i++) begin
					e = sh_store[i];
					if ((e >> 5) == cur) begin
						grp[ng] = e;
						ng++;
					end else begin
						sh_store[keep] = e;
						keep++;
					end
				end
				sh_count = keep;
				// retire coincident events in ascending entry order
				for (int i = 1; i < ng; i++) begin
					v = grp[i];
					j = i;
					while (j > 0 && grp[j-1] > v) begin
						grp[j] = grp[j-1];
						j--;
					end
					grp[j] = v;
				end
				for (int i = 0; i < ng; i++) begin
					e = grp[i];
					ch = e[4:1];
					if (e[0]) res.setm[ch] = 1'b1;
					else res.clrm[ch] = 1'b1;
					sh_left[ch] = sh_left[ch] - 32'd1;
					if (sh_left[ch] != 0) begin
						len = e[0] ? 32'(sh_high[ch]) : 32'(sh_low[ch]);
						store_push(((len << 5) + e) ^ 32'd1);
					end else
						sh_active[ch] = 1'b0;
				end
				if (sh_count != 0) begin
					m = earliest_entry();
					v = (m >> 5) - cur;
					res.ivl = v[15:0];
					if ((m & 32'hf000_0000) != 0)
						for (int i = 0; i < sh_count; i++)
							sh_store[i] &= 32'h0fff_ffff;
				end else
					res.ivl = mpts_pkg::IDLE_INTERVAL;
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic add_req(mpts_pkg::op_t o, logic [15:0] mk, logic [15:0] h,
			logic [15:0] l, logic [15:0] p, logic [30:0] c, bit dr = 1'b0);
		request_t r;
		r = '{o, mk, h, l, p, c, dr};
		pending_q.push_back(r);
	endtask

	// Accept requests and check results
	always @(posedge clk) begin
		event_out_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0)
					report_mismatch("unexpected result", 32'(set_mask), 32'd0);
				else begin
					want = expected_q.pop_front();
					if (set_mask !== want.setm)
						report_mismatch("set_mask", 32'(set_mask), 32'(want.setm));
					if (clear_mask !== want.clrm)
						report_mismatch("clear_mask", 32'(clear_mask), 32'(want.clrm));
					if (next_interval !== want.ivl)
						report_mismatch("next_interval", 32'(next_interval),
							32'(want.ivl));
					if (start_error !== want.err)
						report_mismatch("start_error", 32'(start_error), 32'(want.err));
				end
			end
			taken <= start && !busy;
			if (start && !busy)
				expected_q.push_back(schedule_step(pending_q[0]));
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// Request driver
	always @(negedge clk) begin
		bit go;
		request_t r;
		if (arst_n) begin
			if (start && taken) begin
				void'(pending_q.pop_front());
				taken_count++;
			end
			go = 1'b0;
			if (start && !taken) go = 1'b1;
			else if (pending_q.size() > 0) begin
				r = pending_q[0];
				go = !(r.drain && expected_q.size() != 0);
				if (go && !(taken_count > 200 && taken_count < 320))
					go = $urandom_range(99) >= 17;
			end
			if (go) begin
				r = pending_q[0];
				op <= r.op;
				channel_mask <= r.mask;
				high_len <= r.hi;
				low_len <= r.lo;
				start_phase <= r.ph;
				pulse_count <= r.cnt;
			end
			start <= go;
		end
	end

	always @(posedge clk)
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end

	initial begin
		int n, k;
		logic [15:0] mk;
		sh_count = 0;
		sh_applied = '0;
		sh_active = '0;
		for (int c = 0; c < 16; c++) begin
			sh_left[c] = '0;
			sh_store[c] = '0;
		end
		// directed: empty next, extremes, rejected starts, full store
		add_req(mpts_pkg::OP_NEXT, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 31'h7fff_ffff);
		add_req(mpts_pkg::OP_START, 16'h0001, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_APPLY, 16'h0003, 16'd0, 16'd0, 16'd0, 31'd1);
		add_req(mpts_pkg::OP_START, 16'h0003, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_START, 16'h0001, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_APPLY, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 31'd0);
		add_req(mpts_pkg::OP_START, 16'hffff, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_STOP, 16'hffff, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_APPLY, 16'hffff, 16'd3, 16'd5, 16'd0, 31'h7fff_ffff);
		add_req(mpts_pkg::OP_START, 16'hffff, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_STOP, 16'hffff, 0, 0, 0, 0, 1'b1);
		for (int i = 0; i < 6; i++) add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		// long trains with max lengths to push times past the fold point
		add_req(mpts_pkg::OP_APPLY, 16'h8000, 16'hffff, 16'hffff, 16'd7, 31'd0);
		add_req(mpts_pkg::OP_START, 16'h8000, 0, 0, 0, 0);
		for (int i = 0; i < 150; i++) add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_STOP, 16'h8000, 0, 0, 0, 0);
		add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		// random part: mostly apply/start/next sequences, some noise
		n = 0;
		while (n < 330) begin
			if ($urandom_range(99) < 15) begin
				add_req(mpts_pkg::op_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 31'($urandom));
				n++;
			end else begin
				mk = 16'(1 << $urandom_range(15));
				if ($urandom_range(3) == 0) mk |= 16'($urandom);
				if ($urandom_range(4) == 0)
					add_req(mpts_pkg::OP_APPLY, mk, 16'($urandom), 16'($urandom),
						16'($urandom), 31'($urandom));
				else
					add_req(mpts_pkg::OP_APPLY, mk, 16'($urandom_range(20)),
						16'($urandom_range(20)), 16'($urandom_range(40)),
						31'($urandom_range(6)));
				add_req(mpts_pkg::OP_START, ($urandom_range(9) == 0) ? 16'($urandom) : mk,
					0, 0, 0, 0);
				k = $urandom_range(4, 20);
				for (int i = 0; i < k; i++) add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
				if ($urandom_range(2) == 0)
					add_req(mpts_pkg::OP_STOP, 16'($urandom) & 16'($urandom), 0, 0, 0, 0);
				n += k + 3;
			end
		end
		add_req(mpts_pkg::OP_STOP, 16'hffff, 0, 0, 0, 0, 1'b1);
		for (int i = 0; i < 40; i++) add_req(mpts_pkg::OP_NEXT, 0, 0, 0, 0, 0);
		stim_done = 1'b1;
	end

	// Reset and end of run
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (stim_done && pending_q.size() == 0 && !start && expected_q.size() == 0);
		repeat (600) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
